/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the LRU page replacement checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define LPR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("lpr: implication check failed");

// next-cycle implication, disabled while reset is asserted
`define LPR_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("lpr: next-cycle check failed");

`endif

/* sv/lpr_pkg.sv */
// ----------------------------------------------------------------------------
// LRU page replacement package
// Widths, register codes and the word formats passed along the frame chain.
// ----------------------------------------------------------------------------
package lpr_pkg;

  // default frame count and supported maximum
  localparam int LPR_FRAMES     = 16;
  localparam int LPR_MAX_FRAMES = 64;

  // field widths
  localparam int LPR_PAGE_W  = 20;
  localparam int LPR_CFG_W   = 5;
  localparam int LPR_FIDX_W  = 4;
  localparam int LPR_FAULT_W = 32;
  localparam int LPR_APB_W   = 32;
  localparam int LPR_ADDR_W  = 3;

  // frame position / rank width in chain words, sized for the maximum
  localparam int LPR_POS_W = $clog2(LPR_MAX_FRAMES);

  // register map: index bit of paddr
  localparam logic LPR_REG_FRAMES_IN_USE = 1'b0;

  // frames_in_use after reset
  localparam logic [LPR_CFG_W-1:0] LPR_FIU_RESET = 5'd16;

  // search word carried from frame to frame
  typedef struct packed {
    logic                  hit;
    logic [LPR_POS_W-1:0]  hit_pos;
    logic [LPR_POS_W-1:0]  hit_rank;
    logic                  empty;
    logic [LPR_POS_W-1:0]  empty_pos;
    logic [LPR_POS_W-1:0]  max_pos;
    logic [LPR_POS_W-1:0]  max_rank;
    logic [LPR_PAGE_W-1:0] max_page;
  } lpr_scan_t;

  // update command broadcast to every frame at the end of a lookup
  typedef struct packed {
    logic                 en;
    logic                 clr;
    logic                 write;
    logic                 age_all;
    logic [LPR_POS_W-1:0] slot;
    logic [LPR_POS_W-1:0] old_rank;
  } lpr_upd_t;

endpackage

/* sv/lpr_cell.sv */
// ----------------------------------------------------------------------------
// LRU frame cell
// Holds one page frame (page, valid, age) and folds its contribution into
// the search word coming from the left neighbor, registered to the right.
// ----------------------------------------------------------------------------
module lpr_cell #(
  parameter int POS    = 0,
  parameter int RANK_W = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [lpr_pkg::LPR_PAGE_W-1:0] key_i,
  input  lpr_pkg::lpr_upd_t             upd_i,
  input  lpr_pkg::lpr_scan_t            scan_i,
  output lpr_pkg::lpr_scan_t            scan_o
);
  import lpr_pkg::*;

  localparam logic [LPR_POS_W-1:0] MY_POS = LPR_POS_W'(POS);

  logic [LPR_PAGE_W-1:0] page_q;
  logic                  valid_q;
  logic [RANK_W-1:0]     rank_q;
  logic [LPR_POS_W-1:0]  rank_ext;
  logic                  match;
  lpr_scan_t             scan_d;
  lpr_scan_t             scan_q;

  assign rank_ext = LPR_POS_W'(rank_q);
  assign match    = valid_q && (page_q == key_i);

  // fold this frame into the search word: first hit, first empty, oldest
  always_comb begin
    scan_d = scan_i;
    if (!scan_i.hit && match) begin
      scan_d.hit      = 1'b1;
      scan_d.hit_pos  = MY_POS;
      scan_d.hit_rank = rank_ext;
    end
    if (!scan_i.empty && !valid_q) begin
      scan_d.empty     = 1'b1;
      scan_d.empty_pos = MY_POS;
    end
    if ((POS == 0) || (rank_ext > scan_i.max_rank)) begin
      scan_d.max_pos  = MY_POS;
      scan_d.max_rank = rank_ext;
      scan_d.max_page = page_q;
    end
  end

  // hand the word to the next frame
  always_ff @(posedge clk_i) begin
    scan_q <= scan_d;
  end

  assign scan_o = scan_q;

  // frame state: clear, take the page, or age
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      rank_q  <= '0;
    end else if (upd_i.en) begin
      if (upd_i.clr) begin
        valid_q <= 1'b0;
        rank_q  <= '0;
      end else if (upd_i.slot == MY_POS) begin
        rank_q <= '0;
        if (upd_i.write) begin
          valid_q <= 1'b1;
        end
      end else if (valid_q && (upd_i.age_all || (rank_ext < upd_i.old_rank))) begin
        rank_q <= rank_q + 1'b1;
      end
    end
  end

  // page contents, no reset
  always_ff @(posedge clk_i) begin
    if (upd_i.en && !upd_i.clr && upd_i.write && (upd_i.slot == MY_POS)) begin
      page_q <= key_i;
    end
  end

endmodule

/* sv/lru_page_replacement.sv */
// ----------------------------------------------------------------------------
// LRU page replacement, fully associative
// Looks each page reference up in a chain of frame cells, then hits, fills
// the lowest empty frame or evicts the least recently used one.
// ----------------------------------------------------------------------------
// channel   direction  handshake                       payload
// request   in         start & !busy                   page_number_i, last_reference_i
// result    out        done_o (one cycle, no stall)    page_fault_o .. sequence_end_o
// config    in         psel & penable & pwrite (APB)   paddr, pwdata / prdata
//
// A reference walks the search word one frame per cycle down the cell chain
// over the n taking-part frames, n being the clamped frames_in_use; the edge
// that ends the walk applies the update and loads the result register, and
// done_o shows in the following cycle. busy is low in that cycle, so a new
// word may be taken at its end. Reset empties every frame and clears the fault
// count. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module lru_page_replacement #(
  parameter int FRAMES = lpr_pkg::LPR_FRAMES
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // request
  input  logic                            start,
  output logic                            busy,
  input  logic [lpr_pkg::LPR_PAGE_W-1:0]  page_number_i,
  input  logic                            last_reference_i,
  // result
  output logic                            done_o,
  output logic                            page_fault_o,
  output logic [lpr_pkg::LPR_FIDX_W-1:0]  frame_index_o,
  output logic                            evicted_valid_o,
  output logic [lpr_pkg::LPR_PAGE_W-1:0]  evicted_page_o,
  output logic [lpr_pkg::LPR_FAULT_W-1:0] fault_total_o,
  output logic                            sequence_end_o,
  // configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lpr_pkg::LPR_ADDR_W-1:0]  paddr,
  input  logic [lpr_pkg::LPR_APB_W-1:0]   pwdata,
  output logic [lpr_pkg::LPR_APB_W-1:0]   prdata,
  output logic                            pready
);
  import lpr_pkg::*;

  localparam int IDX_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int RANK_W = IDX_W;
  localparam int CNT_W  = $clog2(FRAMES + 1);

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  state_e                 state_q;
  logic [LPR_CFG_W-1:0]   fiu_q;
  logic [CNT_W-1:0]       n_act;
  logic [CNT_W-1:0]       n_q;
  logic [CNT_W-1:0]       cnt_q;
  logic [LPR_PAGE_W-1:0]  key_q;
  logic                   last_q;
  logic [LPR_FAULT_W-1:0] faults_q;
  logic [LPR_FAULT_W-1:0] faults_nx;
  logic                   accept;
  logic                   scan_done;

  lpr_scan_t              chain [FRAMES+1];
  lpr_scan_t              fin;
  lpr_upd_t               upd;

  // decision fields
  logic                   fault;
  logic                   evict;
  logic [LPR_POS_W-1:0]   slot;

  // registered result word
  logic                   done_q;
  logic                   fault_q;
  logic [LPR_FIDX_W-1:0]  fidx_q;
  logic                   evv_q;
  logic [LPR_PAGE_W-1:0]  evp_q;
  logic                   send_q;

  // APB register, always ready
  assign pready = 1'b1;
  assign prdata = (paddr[2] == LPR_REG_FRAMES_IN_USE) ? LPR_APB_W'(fiu_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fiu_q <= LPR_FIU_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == LPR_REG_FRAMES_IN_USE)) begin
      fiu_q <= pwdata[LPR_CFG_W-1:0];
    end
  end

  // clamp frames_in_use to 1..FRAMES
  always_comb begin
    priority if (fiu_q == '0) begin
      n_act = CNT_W'(1);
    end else if (int'(fiu_q) > FRAMES) begin
      n_act = CNT_W'(FRAMES);
    end else begin
      n_act = CNT_W'(fiu_q);
    end
  end

  // chain head: nothing found yet
  assign chain[0] = '0;

  for (genvar g = 0; g < FRAMES; g++) begin : g_cell
    lpr_cell #(
      .POS    (g),
      .RANK_W (RANK_W)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .key_i  (key_q),
      .upd_i  (upd),
      .scan_i (chain[g]),
      .scan_o (chain[g+1])
    );
  end

  // word after the last taking-part frame
  assign fin       = chain[n_q];
  assign accept    = start && (state_q == ST_IDLE);
  assign scan_done = (state_q == ST_SCAN) && (cnt_q == n_q);
  assign busy      = (state_q == ST_SCAN);

  // hit, fill the first empty frame, or evict the oldest
  always_comb begin
    upd         = '0;
    upd.en      = scan_done;
    upd.clr     = last_q;
    fault       = 1'b1;
    evict       = 1'b0;
    priority if (fin.hit) begin
      fault        = 1'b0;
      slot         = fin.hit_pos;
      upd.old_rank = fin.hit_rank;
    end else if (fin.empty) begin
      slot        = fin.empty_pos;
      upd.write   = 1'b1;
      upd.age_all = 1'b1;
    end else begin
      evict        = 1'b1;
      slot         = fin.max_pos;
      upd.write    = 1'b1;
      upd.old_rank = fin.max_rank;
    end
    upd.slot = slot;
  end

  // saturating fault count
  assign faults_nx = (fault && (faults_q != '1)) ? faults_q + 1'b1 : faults_q;

  // sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      n_q      <= '0;
      cnt_q    <= '0;
      key_q    <= '0;
      last_q   <= 1'b0;
      faults_q <= '0;
      done_q   <= 1'b0;
      fault_q  <= 1'b0;
      fidx_q   <= '0;
      evv_q    <= 1'b0;
      evp_q    <= '0;
      send_q   <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q <= ST_SCAN;
            n_q     <= n_act;
            cnt_q   <= '0;
            key_q   <= page_number_i;
            last_q  <= last_reference_i;
          end
        end
        ST_SCAN: begin
          if (scan_done) begin
            state_q  <= ST_IDLE;
            done_q   <= 1'b1;
            fault_q  <= fault;
            fidx_q   <= LPR_FIDX_W'(slot);
            evv_q    <= evict;
            evp_q    <= evict ? fin.max_page : '0;
            send_q   <= last_q;
            faults_q <= last_q ? '0 : faults_nx;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // the reported total is the count including this reference
  logic [LPR_FAULT_W-1:0] total_q;
  always_ff @(posedge clk_i) begin
    if (scan_done) begin
      total_q <= faults_nx;
    end
  end

  assign done_o          = done_q;
  assign page_fault_o    = fault_q;
  assign frame_index_o   = fidx_q;
  assign evicted_valid_o = evv_q;
  assign evicted_page_o  = evp_q;
  assign fault_total_o   = total_q;
  assign sequence_end_o  = send_q;

endmodule

/* sv/lpr_chk.sv */
// ----------------------------------------------------------------------------
// LRU page replacement checker
// Port-level properties of the lookup sequencing, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lpr_chk (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic done_o,
  input logic page_fault_o,
  input logic evicted_valid_o
);

  // an accepted word occupies the block
  `LPR_ASSERT_NXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy)

  // a result only ends a lookup
  `LPR_ASSERT_IMP(a_done_after_busy, clk_i, rst_ni, done_o, $past(busy))

  // the block is free again when the result shows
  `LPR_ASSERT_IMP(a_done_idle, clk_i, rst_ni, done_o, !busy)

  // a hit never evicts
  `LPR_ASSERT_IMP(a_hit_no_evict, clk_i, rst_ni, done_o && !page_fault_o, !evicted_valid_o)

endmodule

bind lru_page_replacement lpr_chk u_lpr_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .busy            (busy),
  .done_o          (done_o),
  .page_fault_o    (page_fault_o),
  .evicted_valid_o (evicted_valid_o)
);

/* tb/lru_page_replacement_tb.sv */
// ----------------------------------------------------------------------------
// LRU page replacement testbench
// Streams page references into the frame set under several frame counts and
// idle patterns. Every accepted word is run through a local LRU predictor, and
// each result strobe is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module lru_page_replacement_tb;
  import lpr_pkg::*;

  // register addresses: index bit above the byte offset
  localparam logic [LPR_ADDR_W-1:0] FIU_ADDR    = {LPR_REG_FRAMES_IN_USE, 2'b00};
  localparam logic [LPR_ADDR_W-1:0] UNUSED_ADDR = {~LPR_REG_FRAMES_IN_USE, 2'b00};
  localparam logic [LPR_PAGE_W-1:0] PAGE_MAX    = '1;
  localparam int                    PHASES      = 8;
  localparam int                    PHASE_REFS  = 88;
  localparam int                    POOL_DEPTH  = 24;

  typedef struct packed {
    logic [LPR_PAGE_W-1:0] page;
    logic                  last;
  } page_ref_t;

  typedef struct packed {
    logic                   fault;
    logic [LPR_FIDX_W-1:0]  frame;
    logic                   ev_valid;
    logic [LPR_PAGE_W-1:0]  ev_page;
    logic [LPR_FAULT_W-1:0] total;
    logic                   seq_end;
  } page_result_t;

  logic                   clk_i;
  logic                   rst_ni           = 1'b0;
  logic                   start            = 1'b0;
  logic                   busy;
  logic [LPR_PAGE_W-1:0]  page_number_i    = '0;
  logic                   last_reference_i = 1'b0;
  logic                   done_o;
  logic                   page_fault_o;
  logic [LPR_FIDX_W-1:0]  frame_index_o;
  logic                   evicted_valid_o;
  logic [LPR_PAGE_W-1:0]  evicted_page_o;
  logic [LPR_FAULT_W-1:0] fault_total_o;
  logic                   sequence_end_o;
  logic                   psel             = 1'b0;
  logic                   penable          = 1'b0;
  logic                   pwrite           = 1'b0;
  logic [LPR_ADDR_W-1:0]  paddr            = '0;
  logic [LPR_APB_W-1:0]   pwdata           = '0;
  logic [LPR_APB_W-1:0]   prdata;
  logic                   pready;

  // predictor copy of the frame store and the register
  logic [LPR_PAGE_W-1:0]  frame_pages [LPR_FRAMES];
  bit                     frame_full  [LPR_FRAMES];
  int                     frame_age   [LPR_FRAMES];
  logic [LPR_FAULT_W-1:0] fault_count;
  logic [LPR_CFG_W-1:0]   frames_cfg;

  page_ref_t    pending_refs[$];
  page_result_t expected_results[$];
  page_ref_t    next_ref;
  page_result_t want;
  int unsigned  idle_pct       = 0;
  int           mismatch_count = 0;

  lru_page_replacement dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .page_number_i    (page_number_i),
    .last_reference_i (last_reference_i),
    .done_o           (done_o),
    .page_fault_o     (page_fault_o),
    .frame_index_o    (frame_index_o),
    .evicted_valid_o  (evicted_valid_o),
    .evicted_page_o   (evicted_page_o),
    .fault_total_o    (fault_total_o),
    .sequence_end_o   (sequence_end_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // empty every frame and restart the fault count
  function automatic void clear_frames();
    for (int i = 0; i < LPR_FRAMES; i++) begin
      frame_pages[i] = '0;
      frame_full[i]  = 1'b0;
      frame_age[i]   = 0;
    end
    fault_count = '0;
  endfunction

  // look one reference up, update the store, return the expected result word
  function automatic page_result_t lru_lookup(logic [LPR_PAGE_W-1:0] page, logic last);
    page_result_t res;
    int n;
    int hit;
    int slot;
    int old_age;
    res  = '0;
    n    = int'(frames_cfg);
    hit  = -1;
    slot = -1;
    if (n < 1) n = 1;
    if (n > LPR_FRAMES) n = LPR_FRAMES;
    // lowest matching frame wins, even with duplicates
    for (int i = 0; i < n; i++)
      if (hit < 0 && frame_full[i] && frame_pages[i] == page) hit = i;
    if (hit >= 0) begin
      slot = hit;
    end else begin
      res.fault = 1'b1;
      for (int i = 0; i < n; i++)
        if (slot < 0 && !frame_full[i]) slot = i;
      if (slot < 0) begin
        // all taking part are full: oldest goes
        slot = 0;
        for (int i = 1; i < n; i++)
          if (frame_age[i] > frame_age[slot]) slot = i;
        res.ev_valid = 1'b1;
        res.ev_page  = frame_pages[slot];
      end
    end
    // make slot most recent; younger valid frames age by one
    old_age = frame_full[slot] ? frame_age[slot] : LPR_FRAMES;
    for (int i = 0; i < LPR_FRAMES; i++)
      if (i != slot && frame_full[i] && frame_age[i] < old_age) frame_age[i]++;
    frame_age[slot] = 0;
    if (res.fault) begin
      frame_pages[slot] = page;
      frame_full[slot]  = 1'b1;
      if (fault_count != '1) fault_count++;
    end
    res.frame   = slot[LPR_FIDX_W-1:0];
    res.total   = fault_count;
    res.seq_end = last;
    if (last) clear_frames();
    return res;
  endfunction

  task automatic queue_ref(logic [LPR_PAGE_W-1:0] page, logic last);
    page_ref_t r;
    r.page = page;
    r.last = last;
    pending_refs.push_back(r);
  endtask

  // wait until every queued word is taken and every result is back
  task automatic drain();
    while (pending_refs.size() != 0 || start || expected_results.size() != 0)
      @(posedge clk_i);
  endtask

  // APB write: setup, then access until pready
  task automatic apb_write(logic [LPR_ADDR_W-1:0] addr, logic [LPR_APB_W-1:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr[LPR_ADDR_W-1:2] == LPR_REG_FRAMES_IN_USE) frames_cfg = data[LPR_CFG_W-1:0];
  endtask

  task automatic check_field(string name, logic [63:0] exp, logic [63:0] act);
    if (act !== exp) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp, act);
      mismatch_count++;
    end
  endtask

  // driver: present the next word once the current one is taken
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start            <= 1'b0;
      page_number_i    <= '0;
      last_reference_i <= 1'b0;
    end else begin
      if (start && !busy)
        expected_results.push_back(lru_lookup(page_number_i, last_reference_i));
      if (!start || !busy) begin
        if (pending_refs.size() != 0 && $urandom_range(99) >= idle_pct) begin
          next_ref          = pending_refs.pop_front();
          start            <= 1'b1;
          page_number_i    <= next_ref.page;
          last_reference_i <= next_ref.last;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: one result word per done strobe
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result with nothing expected, expected none, actual frame %0d",
                 $time, frame_index_o);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("page_fault", 64'(want.fault), 64'(page_fault_o));
        check_field("frame_index", 64'(want.frame), 64'(frame_index_o));
        check_field("evicted_valid", 64'(want.ev_valid), 64'(evicted_valid_o));
        check_field("evicted_page", 64'(want.ev_page), 64'(evicted_page_o));
        check_field("fault_total", 64'(want.total), 64'(fault_total_o));
        check_field("sequence_end", 64'(want.seq_end), 64'(sequence_end_o));
      end
    end
  end

  // stimulus
  initial begin
    logic [LPR_PAGE_W-1:0] pool[POOL_DEPTH];
    logic [LPR_PAGE_W-1:0] page;
    logic                  last;
    int                    n_act;
    int                    pool_n;
    clear_frames();
    frames_cfg = LPR_FIU_RESET;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: page extremes, hits, end of sequence at reset frame count
    queue_ref('0, 1'b0);
    queue_ref(PAGE_MAX, 1'b0);
    queue_ref('0, 1'b0);
    queue_ref(PAGE_MAX, 1'b1);
    drain();
    // zero frame count acts as one frame: back-to-back evictions
    apb_write(FIU_ADDR, 0);
    queue_ref(20'h00005, 1'b0);
    queue_ref(20'h00005, 1'b0);
    queue_ref(20'hAAAAA, 1'b0);
    queue_ref(20'h55555, 1'b1);
    drain();
    // three frames, then shrink mid-sequence so a duplicate appears
    apb_write(FIU_ADDR, 3);
    queue_ref(20'h00001, 1'b0);
    queue_ref(20'h00002, 1'b0);
    queue_ref(20'h00003, 1'b0);
    queue_ref(20'h00004, 1'b0);
    drain();
    apb_write(FIU_ADDR, 1);
    queue_ref(20'h00003, 1'b0);
    queue_ref(20'h00003, 1'b0);
    drain();
    // oversized count acts as full set; write to an unmapped index is ignored
    apb_write(FIU_ADDR, 31);
    apb_write(UNUSED_ADDR, 2);
    queue_ref(20'h00003, 1'b0);
    queue_ref(20'h00002, 1'b0);
    queue_ref(20'h00007, 1'b0);
    queue_ref(20'h00003, 1'b1);
    drain();

    // random phases: references mostly from a small page pool so hits occur
    foreach (pool[i]) pool[i] = LPR_PAGE_W'($urandom);
    for (int p = 0; p < PHASES; p++) begin
      unique case (p)
        0: apb_write(FIU_ADDR, LPR_FRAMES);
        1: apb_write(FIU_ADDR, 1);
        2: apb_write(FIU_ADDR, 31);
        3: apb_write(FIU_ADDR, 0);
        default: apb_write(FIU_ADDR, $urandom_range(0, 31));
      endcase
      if (p % 2 == 1) apb_write(UNUSED_ADDR, $urandom);
      unique case (p % 4)
        1: idle_pct = 75;
        3: idle_pct = 24;
        default: idle_pct = 0;
      endcase
      n_act = int'(frames_cfg);
      if (n_act < 1) n_act = 1;
      if (n_act > LPR_FRAMES) n_act = LPR_FRAMES;
      pool_n = n_act + int'($urandom_range(0, 4));
      for (int k = 0; k < PHASE_REFS; k++) begin
        if ($urandom_range(99) < 88) page = pool[$urandom_range(pool_n - 1)];
        else page = LPR_PAGE_W'($urandom);
        last = ($urandom_range(39) == 0);
        queue_ref(page, last);
        if (last && $urandom_range(1) == 1) foreach (pool[i]) pool[i] = LPR_PAGE_W'($urandom);
      end
      drain();
    end

    repeat (LPR_FRAMES + 4) @(posedge clk_i);
    if (mismatch_count == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

  // run limit
  initial begin
    #4800000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
